[sv/pcl_pkg.sv]
// Shared widths, constants and pipeline payload types of the color lerp block.
package pcl_pkg;

	// Fraction bits of the progress input; one full step equals 2**FRAC_BITS.
	localparam int FRAC_BITS = 16;
	localparam int PROG_W    = 18;
	localparam int WIDE_BITS = (FRAC_BITS > PROG_W) ? FRAC_BITS : PROG_W;

	// Alpha path: (ta - sa) * p, then sa * ONE added.
	localparam int A_MUL_W = 9 + PROG_W;
	localparam int A_NUM_W = 10 + WIDE_BITS;
	localparam int A_W     = 8 + FRAC_BITS;

	// Color path: premultiplied channels and their interpolation.
	localparam int PM_W    = 16;
	localparam int C_MUL_W = PM_W + 1 + PROG_W;
	localparam int C_NUM_W = PM_W + 2 + WIDE_BITS;

	// Divider: numerator 2c + a, denominator 2a, eight quotient bits.
	localparam int N_W   = C_NUM_W + 1;
	localparam int D_W   = A_W + 1;
	localparam int Q_W   = 8;
	localparam int R_W   = D_W + Q_W;
	localparam int LANES = 3;

	localparam logic [A_W-1:0] A_MAX  = {8'hFF, {FRAC_BITS{1'b0}}};
	localparam logic [A_W:0]   A_HALF = (A_W + 1)'(1) << (FRAC_BITS - 1);

	typedef struct packed {
		logic [R_W-1:0] rem;
		logic [Q_W-1:0] quo;
		logic           sat;
	} lane_t;

	typedef struct packed {
		lane_t [LANES-1:0] lane;
		logic [D_W-1:0]    den;
		logic [7:0]        alpha;
		logic              clear;
	} div_t;

endpackage

[sv/pcl_in_if.sv]
// Request channel carrying the progress and the two colors to blend.
interface pcl_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [pcl_pkg::PROG_W-1:0] progress;
	logic [31:0]                        start_argb;
	logic [31:0]                        target_argb;

	modport source(output valid, progress, start_argb, target_argb, input ready);
	modport sink(input valid, progress, start_argb, target_argb, output ready);
endinterface

[sv/pcl_out_if.sv]
// Result channel carrying the blended color.
interface pcl_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] blended_argb;

	modport source(output valid, blended_argb, input ready);
	modport sink(input valid, blended_argb, output ready);
endinterface

[sv/pcl_divider.sv]
// Pipelined restoring divider: one quotient bit per stage for all three channels.
module pcl_divider (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  pcl_pkg::div_t req_data,
	output logic          res_valid,
	input  logic          res_ready,
	output pcl_pkg::div_t res_data
);

	localparam int STEPS = pcl_pkg::Q_W;

	logic [STEPS-1:0] valid_s;
	logic [STEPS-1:0] valid_d;
	logic [STEPS:0]   en;
	pcl_pkg::div_t    data_s [STEPS];
	pcl_pkg::div_t    src_d  [STEPS];
	pcl_pkg::div_t    next_d [STEPS];

	assign en[STEPS]  = res_ready;
	assign req_ready  = en[0];
	assign res_valid  = valid_s[STEPS-1];
	assign res_data   = data_s[STEPS-1];
	assign src_d[0]   = req_data;
	assign valid_d[0] = req_valid;

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam int K = STEPS - 1 - j;

		assign en[j] = ~valid_s[j] | en[j+1];

		if (j > 0) begin : g_src
			assign src_d[j]   = data_s[j-1];
			assign valid_d[j] = valid_s[j-1];
		end

		always_comb begin
			logic [pcl_pkg::R_W-1:0] shifted;
			logic [pcl_pkg::R_W:0]   diff;
			next_d[j] = src_d[j];
			shifted   = pcl_pkg::R_W'(src_d[j].den) << K;
			for (int l = 0; l < pcl_pkg::LANES; l++) begin
				diff = {1'b0, src_d[j].lane[l].rem} - {1'b0, shifted};
				// No borrow means the shifted divisor fits into the remainder.
				if (!diff[pcl_pkg::R_W]) begin
					next_d[j].lane[l].rem    = diff[pcl_pkg::R_W-1:0];
					next_d[j].lane[l].quo[K] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (en[j]) begin
				valid_s[j] <= valid_d[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				data_s[j] <= next_d[j];
			end
		end
	end

endmodule

[sv/premultiplied_color_lerp.sv]
// Premultiplied-alpha interpolation of two ARGB colors, fully pipelined.
//
// A request on colors carries a signed Q2.16 progress and a start and a
// target color (8-bit A, R, G, B). Alpha is interpolated linearly; each color
// channel is interpolated in premultiplied form and divided back by the
// blended alpha with round-half-up, saturated to 0..255. A blended alpha that
// is not positive gives an all-zero result. One result leaves on blend for
// every request, in request order.
//
// Throughput is one request per cycle when nothing stalls. From acceptance
// to the result showing on blend, a request passes through five stages of
// multiply, add and compare, eight stages of the restoring divider (one
// quotient bit each), and the output register.
//
// Reset empties every stage; no result is pending afterwards. Each stage
// moves on when it is empty or the stage after it moves, so a stalled
// receiver first fills the bubbles and only then holds colors.ready low.
// Nothing is lost or repeated under stall.
module premultiplied_color_lerp (
	input logic       clk,
	input logic       arst_n,
	pcl_in_if.sink    colors,
	pcl_out_if.source blend
);

	localparam int L = pcl_pkg::LANES;

	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_out;
	logic div_ready, div_valid;
	pcl_pkg::div_t div_out;

	// Stage 1: byte products.
	logic                                  valid_s1;
	logic signed [pcl_pkg::PROG_W-1:0]    p_s1;
	logic [7:0]                            sa_s1;
	logic signed [pcl_pkg::A_MUL_W-1:0]   a_prod_s1;
	logic [pcl_pkg::PM_W-1:0]              s_pm_s1 [L];
	logic [pcl_pkg::PM_W-1:0]              t_pm_s1 [L];
	logic signed [8:0]                     a_diff;
	logic signed [pcl_pkg::A_MUL_W-1:0]   a_prod;
	logic [pcl_pkg::PM_W-1:0]              s_pm [L];
	logic [pcl_pkg::PM_W-1:0]              t_pm [L];

	// Stage 2: channel products, alpha sum and clamp.
	logic                                  valid_s2;
	logic                                  clear_s2;
	logic [pcl_pkg::A_W-1:0]               a_s2;
	logic [pcl_pkg::PM_W-1:0]              s_pm_s2 [L];
	logic signed [pcl_pkg::C_MUL_W-1:0]   c_prod_s2 [L];
	logic signed [pcl_pkg::PM_W:0]         c_diff [L];
	logic signed [pcl_pkg::C_MUL_W-1:0]   c_prod [L];
	logic signed [pcl_pkg::A_NUM_W-1:0]   a_num;
	logic                                  a_clear;
	logic [pcl_pkg::A_W-1:0]               a_clamp;

	// Stage 3: channel sums and rounded alpha.
	logic                                  valid_s3;
	logic                                  clear_s3;
	logic [pcl_pkg::A_W-1:0]               a_s3;
	logic [7:0]                            alpha_s3;
	logic signed [pcl_pkg::C_NUM_W-1:0]   c_num_s3 [L];
	logic signed [pcl_pkg::C_NUM_W-1:0]   c_num [L];
	logic [pcl_pkg::A_W:0]                 alpha_sum;

	// Stage 4: numerators and denominator of the rounded division.
	logic                                  valid_s4;
	logic                                  clear_s4;
	logic [7:0]                            alpha_s4;
	logic [pcl_pkg::D_W-1:0]               den_s4;
	logic [pcl_pkg::N_W-1:0]               n_s4 [L];
	logic [pcl_pkg::N_W-1:0]               n_next [L];

	// Stage 5: saturation check, divider entry.
	logic                                  valid_s5;
	pcl_pkg::div_t                         div_s5;
	pcl_pkg::div_t                         div_next;

	// Output register.
	logic                                  valid_q;
	logic [31:0]                           argb_q;
	logic [31:0]                           argb_next;

	assign en_out       = ~valid_q | blend.ready;
	assign en_s5        = ~valid_s5 | div_ready;
	assign en_s4        = ~valid_s4 | en_s5;
	assign en_s3        = ~valid_s3 | en_s4;
	assign en_s2        = ~valid_s2 | en_s3;
	assign en_s1        = ~valid_s1 | en_s2;
	assign colors.ready = en_s1;

	always_comb begin
		a_diff = $signed({1'b0, colors.target_argb[31:24]})
			- $signed({1'b0, colors.start_argb[31:24]});
		a_prod = a_diff * colors.progress;
		for (int i = 0; i < L; i++) begin
			s_pm[i] = colors.start_argb[16-8*i +: 8] * colors.start_argb[31:24];
			t_pm[i] = colors.target_argb[16-8*i +: 8] * colors.target_argb[31:24];
		end
	end

	always_comb begin
		for (int i = 0; i < L; i++) begin
			c_diff[i] = $signed({1'b0, t_pm_s1[i]}) - $signed({1'b0, s_pm_s1[i]});
			c_prod[i] = c_diff[i] * p_s1;
		end
		a_num   = $signed(pcl_pkg::A_NUM_W'({sa_s1, {pcl_pkg::FRAC_BITS{1'b0}}}))
			+ pcl_pkg::A_NUM_W'(a_prod_s1);
		a_clear = (a_num <= 0);
		if (a_num > $signed(pcl_pkg::A_NUM_W'(pcl_pkg::A_MAX))) begin
			a_clamp = pcl_pkg::A_MAX;
		end else begin
			a_clamp = a_num[pcl_pkg::A_W-1:0];
		end
	end

	always_comb begin
		for (int i = 0; i < L; i++) begin
			c_num[i] = $signed(pcl_pkg::C_NUM_W'({s_pm_s2[i], {pcl_pkg::FRAC_BITS{1'b0}}}))
				+ pcl_pkg::C_NUM_W'(c_prod_s2[i]);
		end
		alpha_sum = (pcl_pkg::A_W + 1)'(a_s2) + pcl_pkg::A_HALF;
	end

	always_comb begin
		// A channel that is not positive gets a zero numerator and so a zero quotient.
		for (int i = 0; i < L; i++) begin
			if (c_num_s3[i] > 0) begin
				n_next[i] = pcl_pkg::N_W'({c_num_s3[i][pcl_pkg::C_NUM_W-2:0], 1'b0})
					+ pcl_pkg::N_W'(a_s3);
			end else begin
				n_next[i] = '0;
			end
		end
	end

	always_comb begin
		div_next.den   = den_s4;
		div_next.alpha = alpha_s4;
		div_next.clear = clear_s4;
		for (int i = 0; i < L; i++) begin
			div_next.lane[i].sat = (n_s4[i] >= pcl_pkg::N_W'({den_s4, {pcl_pkg::Q_W{1'b0}}}));
			div_next.lane[i].rem = div_next.lane[i].sat ? '0 : n_s4[i][pcl_pkg::R_W-1:0];
			div_next.lane[i].quo = '0;
		end
	end

	always_comb begin
		argb_next[31:24] = div_out.alpha;
		for (int i = 0; i < L; i++) begin
			argb_next[16-8*i +: 8] = div_out.lane[i].sat ? 8'hFF : div_out.lane[i].quo;
		end
		if (div_out.clear) begin
			argb_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= colors.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_out) valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			p_s1      <= colors.progress;
			sa_s1     <= colors.start_argb[31:24];
			a_prod_s1 <= a_prod;
			s_pm_s1   <= s_pm;
			t_pm_s1   <= t_pm;
		end
		if (en_s2) begin
			clear_s2  <= a_clear;
			a_s2      <= a_clamp;
			s_pm_s2   <= s_pm_s1;
			c_prod_s2 <= c_prod;
		end
		if (en_s3) begin
			clear_s3 <= clear_s2;
			a_s3     <= a_s2;
			alpha_s3 <= alpha_sum[pcl_pkg::FRAC_BITS +: 8];
			c_num_s3 <= c_num;
		end
		if (en_s4) begin
			clear_s4 <= clear_s3;
			alpha_s4 <= alpha_s3;
			den_s4   <= {a_s3, 1'b0};
			n_s4     <= n_next;
		end
		if (en_s5) begin
			div_s5 <= div_next;
		end
		if (en_out) begin
			argb_q <= argb_next;
		end
	end

	pcl_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (valid_s5),
		.req_ready (div_ready),
		.req_data  (div_s5),
		.res_valid (div_valid),
		.res_ready (en_out),
		.res_data  (div_out)
	);

	assign blend.valid        = valid_q;
	assign blend.blended_argb = argb_q;

	// With the output register empty every stage can move, so a request is taken.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!blend.valid |-> colors.ready)
		else $error("request refused while the output register is empty");

	// A visible alpha is positive and never beyond opaque.
	a_alpha_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !clear_s2 |-> (a_s2 != '0) && (a_s2 <= pcl_pkg::A_MAX))
		else $error("blended alpha out of range after clamp");

	// After the last quotient bit every remainder lies below the divisor.
	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid && !div_out.clear |->
			(div_out.lane[0].rem < pcl_pkg::R_W'(div_out.den)) &&
			(div_out.lane[1].rem < pcl_pkg::R_W'(div_out.den)) &&
			(div_out.lane[2].rem < pcl_pkg::R_W'(div_out.den)))
		else $error("divider remainder not below divisor");

endmodule

[bench/tb.sv]
// Self-checking bench for the premultiplied color lerp: directed table, then random requests.
`timescale 1ns / 100ps

module tb;
	import pcl_pkg::*;

	localparam int     ONE        = 1 << FRAC_BITS;
	localparam longint ONE_L      = longint'(ONE);
	localparam int     RANDOM_CNT = 1600;
	localparam int     LIMIT      = 200000;
	localparam int     N_DIRECTED = 21;

	typedef struct packed {
		logic [PROG_W-1:0] prog;
		logic [31:0]       src;
		logic [31:0]       dst;
		logic              typed;
		logic [31:0]       want;
	} dir_row_t;

	// Rows with typed set carry a result that follows at a glance: p = 0 gives
	// the start color, one full step gives the target, and no alpha gives zero.
	dir_row_t directed_rows [0:N_DIRECTED-1] = '{
		'{PROG_W'(0),        32'h00FF_FFFF, 32'h0012_3456, 1'b1, 32'h0000_0000},
		'{PROG_W'(0),        32'hFF10_2030, 32'h00AB_CDEF, 1'b1, 32'hFF10_2030},
		'{PROG_W'(ONE),      32'h00AB_CDEF, 32'hFF40_5060, 1'b1, 32'hFF40_5060},
		'{PROG_W'(0),        32'h80FF_7F01, 32'hFFFF_FFFF, 1'b1, 32'h80FF_7F01},
		'{PROG_W'(ONE),      32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 32'h9ABC_DEF0},
		'{PROG_W'(-1),       32'h00FF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		'{PROG_W'(131071),   32'hFF00_0000, 32'h00FF_FFFF, 1'b1, 32'h0000_0000},
		'{PROG_W'(-131072),  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		'{PROG_W'(131071),   32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
		'{PROG_W'(-131072),  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
		'{PROG_W'(131071),   32'hFFFF_FFFF, 32'hFF00_0000, 1'b0, 32'h0},
		'{PROG_W'(-131072),  32'hFF00_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
		'{PROG_W'(1),        32'h0000_0000, 32'h01FF_FFFF, 1'b0, 32'h0},
		'{PROG_W'(ONE / 2),  32'h00FF_0000, 32'hFF00_FF00, 1'b0, 32'h0},
		'{PROG_W'(ONE / 2),  32'h0101_0101, 32'h0202_0202, 1'b0, 32'h0},
		'{PROG_W'(-ONE),     32'hFF80_8080, 32'h8040_4040, 1'b0, 32'h0},
		'{PROG_W'(131071),   32'h4011_2233, 32'h80EE_DDCC, 1'b0, 32'h0},
		'{PROG_W'(ONE / 3),  32'h7F3C_5A96, 32'hC0E1_D2F0, 1'b0, 32'h0},
		'{PROG_W'(-ONE / 2), 32'h40FF_FFFF, 32'h2000_0000, 1'b0, 32'h0},
		'{PROG_W'(1),        32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
		'{PROG_W'(ONE + 1),  32'h0100_0000, 32'h02FF_FFFF, 1'b0, 32'h0}
	};

	logic clk = 1'b0;
	logic arst_n;

	pcl_in_if  colors_if ();
	pcl_out_if blend_if ();

	premultiplied_color_lerp dut (
		.clk    (clk),
		.arst_n (arst_n),
		.colors (colors_if),
		.blend  (blend_if)
	);

	always #6 clk = ~clk;

	logic [31:0] expected_colors [$];
	logic        cur_typed;
	logic [31:0] cur_want;
	logic        idle_on;
	int          errors;
	int          requests;
	int          results;
	int          transparent;
	int          cycles;

	// Premultiplied interpolation with exact integer arithmetic.
	function automatic logic [31:0] blend_color(input logic signed [PROG_W-1:0] prog,
	                                            input logic [31:0] src,
	                                            input logic [31:0] dst);
		longint      p, sa, ta, a_num, sc, tc, c_num, q;
		int          sh;
		logic [31:0] res;
		p     = longint'(prog);
		sa    = longint'(src[31:24]);
		ta    = longint'(dst[31:24]);
		a_num = sa * ONE_L + (ta - sa) * p;
		if (a_num <= 0) begin
			return 32'h0;
		end
		if (a_num > 255 * ONE_L) begin
			a_num = 255 * ONE_L;
		end
		res        = '0;
		q          = (a_num + ONE_L / 2) / ONE_L;
		res[31:24] = q[7:0];
		for (int i = 0; i < 3; i++) begin
			sh    = 16 - 8 * i;
			sc    = longint'(src[sh +: 8]);
			tc    = longint'(dst[sh +: 8]);
			c_num = sc * sa * ONE_L + (tc * ta - sc * sa) * p;
			if (c_num <= 0) begin
				q = 0;
			end else begin
				q = (2 * c_num + a_num) / (2 * a_num);
				if (q > 255) begin
					q = 255;
				end
			end
			res[sh +: 8] = q[7:0];
		end
		return res;
	endfunction

	task automatic send_request(input logic [PROG_W-1:0] prog, input logic [31:0] src,
	                            input logic [31:0] dst, input logic typed,
	                            input logic [31:0] want);
		while (idle_on && $urandom_range(99) < 26) begin
			colors_if.valid <= 1'b0;
			@(posedge clk);
		end
		colors_if.valid       <= 1'b1;
		colors_if.progress    <= prog;
		colors_if.start_argb  <= src;
		colors_if.target_argb <= dst;
		cur_typed             <= typed;
		cur_want              <= want;
		do @(posedge clk); while (!colors_if.ready);
	endtask

	function automatic logic [7:0] pick_alpha();
		int r;
		r = $urandom_range(9);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hFF;
		return 8'($urandom());
	endfunction

	function automatic logic [23:0] pick_rgb();
		int r;
		r = $urandom_range(15);
		if (r == 0) return 24'h000000;
		if (r == 1) return 24'hFFFFFF;
		return 24'($urandom());
	endfunction

	function automatic logic [PROG_W-1:0] pick_progress();
		int r;
		r = $urandom_range(9);
		if (r < 5) return PROG_W'($urandom_range(ONE, 0));
		if (r < 8) return PROG_W'($urandom());
		if (r == 8) return PROG_W'(int'($urandom_range(16)) - 8);
		return PROG_W'(ONE + int'($urandom_range(16)) - 8);
	endfunction

	// Receiver: stalls at random while idling is on.
	initial begin
		blend_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			blend_if.ready <= idle_on ? ($urandom_range(99) >= 26) : 1'b1;
		end
	end

	// Predict on every accepted request, check every accepted result.
	always @(posedge clk) begin : check_blk
		logic [31:0] want;
		if (arst_n && colors_if.valid && colors_if.ready) begin
			requests++;
			if (cur_typed) begin
				expected_colors.push_back(cur_want);
			end else begin
				expected_colors.push_back(blend_color(colors_if.progress,
					colors_if.start_argb, colors_if.target_argb));
			end
		end
		if (arst_n && blend_if.valid && blend_if.ready) begin
			results++;
			if (expected_colors.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %08h",
				         $time, blend_if.blended_argb);
			end else begin
				want = expected_colors.pop_front();
				if (want == 32'h0) begin
					transparent++;
				end
				if (blend_if.blended_argb !== want) begin
					errors++;
					$display("%0t: blended_argb expected %08h, actual %08h",
					         $time, want, blend_if.blended_argb);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("premultiplied_color_lerp: mismatch");
			$finish;
		end
	end

	initial begin
		errors      = 0;
		requests    = 0;
		results     = 0;
		transparent = 0;
		cycles      = 0;
		arst_n      = 1'b0;
		colors_if.valid       <= 1'b0;
		colors_if.progress    <= '0;
		colors_if.start_argb  <= '0;
		colors_if.target_argb <= '0;
		cur_typed             <= 1'b0;
		cur_want              <= '0;
		idle_on               <= 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_request(directed_rows[i].prog, directed_rows[i].src, directed_rows[i].dst,
			             directed_rows[i].typed, directed_rows[i].want);
		end

		// Random requests 600 to 1099 run with no idling on either side.
		for (int i = 0; i < RANDOM_CNT; i++) begin
			if (i == 600) idle_on <= 1'b0;
			if (i == 1100) idle_on <= 1'b1;
			send_request(pick_progress(), {pick_alpha(), pick_rgb()},
			             {pick_alpha(), pick_rgb()}, 1'b0, 32'h0);
		end
		colors_if.valid <= 1'b0;

		while (expected_colors.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("Blended %0d color pairs (%0d directed), %0d results checked,", requests,
		         N_DIRECTED, results);
		$display("%0d of them fully transparent; %0d errors.", transparent, errors);
		if (errors == 0 && expected_colors.size() == 0) begin
			$display("premultiplied_color_lerp: match");
		end else begin
			$display("premultiplied_color_lerp: mismatch");
		end
		$finish;
	end

endmodule

[sim.f]
sv/pcl_pkg.sv
sv/pcl_in_if.sv
sv/pcl_out_if.sv
sv/pcl_divider.sv
sv/premultiplied_color_lerp.sv
bench/tb.sv
